// ===== src/mtd_pkg.sv =====
// mtd_pkg: shared types, codes and character tables for the mime transfer decoder
// depends on nothing; imported by every module of the block

package mtd_pkg;

  localparam int unsigned CapW = 17;

  // decode modes
  localparam logic [1:0] ModePass = 2'd0;
  localparam logic [1:0] ModeB64  = 2'd1;
  localparam logic [1:0] ModeQp   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CfgIdxMode = 2'd0;
  localparam logic [1:0] CfgIdxCap  = 2'd1;

  // escape tracking codes
  localparam logic [1:0] EscNone  = 2'd0;
  localparam logic [1:0] EscEq    = 2'd1;
  localparam logic [1:0] EscFirst = 2'd2;

  localparam logic [7:0] CharEq = 8'h3D;
  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharLf = 8'h0A;

  localparam logic [1:0]      ResetMode  = ModePass;
  localparam logic [CapW-1:0] ResetLimit = 17'd4095;

  // one input item's worth of results
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      n;
    logic            last;
    logic            status;
  } group_t;

  // base64 alphabet: {valid, value}
  function automatic logic [6:0] b64_value(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c inside {[8'h41:8'h5A]}) begin
      t = c - 8'd65;
      return {1'b1, t[5:0]};
    end
    if (c inside {[8'h61:8'h7A]}) begin
      t = c - 8'd71;
      return {1'b1, t[5:0]};
    end
    if (c inside {[8'h30:8'h39]}) begin
      t = c + 8'd4;
      return {1'b1, t[5:0]};
    end
    if (c == 8'h2B) return {1'b1, 6'd62};
    if (c == 8'h2F) return {1'b1, 6'd63};
    return 7'd0;
  endfunction

  // hex digit: {valid, value}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c inside {[8'h30:8'h39]}) begin
      t = c - 8'd48;
      return {1'b1, t[3:0]};
    end
    if (c inside {[8'h61:8'h66]}) begin
      t = c - 8'd87;
      return {1'b1, t[3:0]};
    end
    if (c inside {[8'h41:8'h46]}) begin
      t = c - 8'd55;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

// ===== src/mtd_decode.sv =====
// mtd_decode: per-stream decode state and the single-pass decode of one byte
// depends on mtd_pkg (codes, character tables, group_t)

module mtd_decode import mtd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      byte_i,
  input  logic            last_i,
  input  logic [1:0]      mode_i,
  input  logic [CapW-1:0] limit_i,
  output group_t          group_o
);

  logic [11:0]     acc_q, acc_d, acc_n;
  logic [3:0]      fill_q, fill_d, fill_sum;
  logic [1:0]      esc_q, esc_d;
  logic [7:0]      first_q, first_d;
  logic [CapW-1:0] cnt_q, cnt_d, avail;
  logic            ovf_q, ovf_d;
  logic [6:0]      b64v;
  logic [4:0]      hi, lo;
  logic [2:0][7:0] cand;
  logic [1:0]      cn, room, emit;

  assign b64v = b64_value(byte_i);
  assign hi   = hex_value(first_q);
  assign lo   = hex_value(byte_i);

  // candidate bytes in emission order
  always_comb begin
    acc_d    = acc_q;
    fill_d   = fill_q;
    esc_d    = esc_q;
    first_d  = first_q;
    cand     = '0;
    cn       = 2'd0;
    acc_n    = {acc_q[5:0], b64v[5:0]};
    fill_sum = fill_q + 4'd6;
    case (mode_i)
      ModeB64: begin
        if (b64v[6]) begin
          acc_d = acc_n;
          if (fill_sum >= 4'd8) begin
            fill_d  = fill_sum - 4'd8;
            cand[0] = 8'(acc_n >> fill_d);
            cn      = 2'd1;
          end else begin
            fill_d = fill_sum;
          end
        end
      end
      ModeQp: begin
        case (esc_q)
          EscNone: begin
            if (byte_i == CharEq && !last_i) begin
              esc_d = EscEq;
            end else begin
              cand[0] = byte_i;
              cn      = 2'd1;
            end
          end
          EscEq: begin
            if (last_i) begin
              cand[0] = CharEq;
              cand[1] = byte_i;
              cn      = 2'd2;
              esc_d   = EscNone;
            end else begin
              first_d = byte_i;
              esc_d   = EscFirst;
            end
          end
          default: begin
            esc_d   = EscNone;
            first_d = 8'd0;
            if (first_q == CharCr && byte_i == CharLf) begin
              cn = 2'd0; // soft line break
            end else if (hi[4] && lo[4]) begin
              cand[0] = {hi[3:0], lo[3:0]};
              cn      = 2'd1;
            end else begin
              cand[0] = CharEq;
              if (first_q == CharEq && !last_i) begin
                esc_d   = EscFirst;
                first_d = byte_i;
                cn      = 2'd1;
              end else begin
                cand[1] = first_q;
                if (byte_i == CharEq && !last_i) begin
                  esc_d = EscEq;
                  cn    = 2'd2;
                end else begin
                  cand[2] = byte_i;
                  cn      = 2'd3;
                end
              end
            end
          end
        endcase
      end
      default: begin
        cand[0] = byte_i;
        cn      = 2'd1;
      end
    endcase
  end

  // capacity limit: emission is always a prefix of the candidates
  always_comb begin
    avail = (cnt_q < limit_i) ? limit_i - cnt_q : '0;
    room  = (avail >= CapW'(3)) ? 2'd3 : avail[1:0];
    emit  = ovf_q ? 2'd0 : ((cn <= room) ? cn : room);
    ovf_d = ovf_q | (cn > room);
    cnt_d = cnt_q + CapW'(emit);
  end

  assign group_o.bytes  = cand;
  assign group_o.n      = emit;
  assign group_o.last   = last_i;
  assign group_o.status = ovf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      fill_q  <= '0;
      esc_q   <= EscNone;
      first_q <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        acc_q   <= '0;
        fill_q  <= '0;
        esc_q   <= EscNone;
        first_q <= '0;
        cnt_q   <= '0;
        ovf_q   <= 1'b0;
      end else begin
        acc_q   <= acc_d;
        fill_q  <= fill_d;
        esc_q   <= esc_d;
        first_q <= first_d;
        cnt_q   <= cnt_d;
        ovf_q   <= ovf_d;
      end
    end
  end

endmodule

// ===== src/mtd_out_queue.sv =====
// mtd_out_queue: small queue of result groups and the serialiser onto the output stream
// depends on mtd_pkg (group_t)

module mtd_out_queue import mtd_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  group_t                     group_i,
  output logic                       full_o,
  output logic [$clog2(Depth+1)-1:0] level_o,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [7:0]                 m_axis_tdata_o,
  output logic [2:0]                 m_axis_tuser_o,
  output logic                       m_axis_tlast_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned LW = $clog2(Depth+1);

  group_t          mem_q [Depth];
  logic [AW-1:0]   wr_q, rd_q;
  logic [LW-1:0]   level_q;
  logic [1:0]      k_q;
  logic [1:0]      nres_m1;
  group_t          head;
  logic            pop, fire;

  assign head    = mem_q[rd_q];
  assign nres_m1 = (head.n == 2'd0) ? 2'd0 : head.n - 2'd1;
  assign fire    = m_axis_tvalid_o && m_axis_tready_i;
  assign pop     = fire && m_axis_tlast_o;

  assign full_o          = (level_q == LW'(Depth));
  assign level_o         = level_q;
  assign m_axis_tvalid_o = (level_q != '0);
  assign m_axis_tlast_o  = (k_q == nres_m1);

  always_comb begin
    case (k_q)
      2'd0:    m_axis_tdata_o = head.bytes[0];
      2'd1:    m_axis_tdata_o = head.bytes[1];
      default: m_axis_tdata_o = head.bytes[2];
    endcase
    if (head.n == 2'd0) m_axis_tdata_o = 8'd0;
  end

  // has_byte, stream_done, status from the low bit up
  assign m_axis_tuser_o = {head.status, head.last, head.n != 2'd0};

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= group_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
      k_q     <= 2'd0;
    end else begin
      if (push_i) wr_q <= (wr_q == AW'(Depth-1)) ? '0 : wr_q + AW'(1);
      if (pop)    rd_q <= (rd_q == AW'(Depth-1)) ? '0 : rd_q + AW'(1);
      if (push_i && !pop)      level_q <= level_q + LW'(1);
      else if (pop && !push_i) level_q <= level_q - LW'(1);
      if (pop)       k_q <= 2'd0;
      else if (fire) k_q <= k_q + 2'd1;
    end
  end

endmodule

// ===== src/mime_transfer_decoder_top.sv =====
// mime_transfer_decoder_top: stream wrapper, configuration registers and input stage
// depends on mtd_pkg, mtd_decode and mtd_out_queue

// Decodes a MIME body byte stream one byte per cycle while the output queue has room:
// pass-through, base64 (bytes outside the alphabet, padding included, are skipped) or
// quoted-printable ('=' plus two hex digits gives one byte, '=' CR LF is dropped, any other
// '=' goes out literally). Each accepted request yields one to three results; a request
// that decodes to nothing yields a single result with has_byte low so that stream end and
// status are still seen. At most out_capacity - 1 bytes leave per stream, after which
// status rises and stays up until the request flagged tlast, which also clears all stream
// state. A byte is taken into the input register, decoded in one pass and written as a
// group into an output queue of GroupDepth entries; the serialiser drains one result per
// cycle while m_axis_tready is high, so the sustained rate is one request per cycle while
// requests give one result each, and a request giving k results occupies the output for k
// transfers, bursts being soaked up by the queue. Configuration is taken at any time but
// should only be written between streams or while idle.

module mime_transfer_decoder_top import mtd_pkg::*; #(
  parameter int unsigned GroupDepth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // input stream
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [7:0]      s_axis_tdata,   // data_byte
  input  logic            s_axis_tlast,   // is_last
  // output stream
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // out_byte
  output logic [2:0]      m_axis_tuser,   // has_byte, stream_done, status
  output logic            m_axis_tlast,   // end_of_run
  // configuration writes
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [CapW-1:0] cfg_data_i
);

  localparam int unsigned LW = $clog2(GroupDepth+1);

  logic [1:0]      mode_q;
  logic [CapW-1:0] limit_q;     // out_capacity - 1, floored at zero
  logic            in_valid_q;
  logic [7:0]      in_byte_q;
  logic            in_last_q;
  logic            q_full;
  logic [LW-1:0]   q_level;
  logic            step;
  group_t          group;

  // configuration: always ready, unknown indexes ignored
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ResetMode;
      limit_q <= ResetLimit;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgIdxMode: mode_q  <= cfg_data_i[1:0];
        CfgIdxCap:  limit_q <= (cfg_data_i == '0) ? '0 : cfg_data_i - CapW'(1);
        default:    ;
      endcase
    end
  end

  // input register; decoded when the queue has room for its group
  assign step          = in_valid_q && !q_full;
  assign s_axis_tready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  mtd_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (in_byte_q),
    .last_i  (in_last_q),
    .mode_i  (mode_q),
    .limit_i (limit_q),
    .group_o (group)
  );

  mtd_out_queue #(
    .Depth (GroupDepth)
  ) u_out_queue (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (step),
    .group_i         (group),
    .full_o          (q_full),
    .level_o         (q_level),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  // queue never holds more groups than it has entries
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_level <= LW'(GroupDepth))
    else $error("output queue level beyond depth");

  // output valid exactly when a group is queued
  a_valid_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid == (q_level != '0))
    else $error("output valid disagrees with queue level");

  // a held request keeps its byte while the queue is full
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step |=> in_valid_q && $stable(in_byte_q) && $stable(in_last_q))
    else $error("stalled input request lost or changed");

endmodule

// ===== dv/testbench.sv =====
// testbench: self-checking bench for mime_transfer_decoder_top (pass-through, base64,
// quoted-printable), with a cycle-free predictor and randomised stalls on both streams
// depends on mtd_pkg and mime_transfer_decoder_top

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mtd_pkg::*;

  // mode 3 has no name in the package; it must act as pass-through
  localparam logic [1:0] ModeReserved = 2'd3;
  localparam int unsigned WatchdogLimit = 3000;

  // one decoded result as it leaves the output stream
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       end_of_run;
    logic       stream_done;
    logic       status;
  } result_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [7:0]      s_axis_tdata = 8'h00;
  logic            s_axis_tlast = 1'b0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [7:0]      m_axis_tdata;
  logic [2:0]      m_axis_tuser;   // has_byte, stream_done, status
  logic            m_axis_tlast;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [1:0]      cfg_index_i = CfgIdxMode;
  logic [CapW-1:0] cfg_data_i = '0;

  // predictor copy of the configuration registers
  logic [1:0]      cur_mode;
  logic [CapW-1:0] cur_capacity;

  // predictor copy of the per-stream decoder state
  logic [11:0]     b64_bits;
  logic [3:0]      b64_fill;
  logic [1:0]      esc_state;
  logic [7:0]      esc_held;
  logic [CapW-1:0] out_count;
  logic            overflowed;

  logic [7:0]      burst_q[$];    // bytes decoded from the current request
  result_t         decoded_q[$];  // results still owed by the block, oldest first
  logic [7:0]      body_q[$];     // encoded bytes waiting to be sent

  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  int              errors = 0;
  int unsigned     stuck_cycles = 0;
  string           hex_digits = "0123456789ABCDEFabcdef";

  mime_transfer_decoder_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------------------

  function automatic void clear_stream_state();
    b64_bits   = '0;
    b64_fill   = '0;
    esc_state  = EscNone;
    esc_held   = '0;
    out_count  = '0;
    overflowed = 1'b0;
  endfunction

  // a decoded byte leaves only while below capacity - 1; the first one beyond trips overflow
  function automatic void put_decoded(logic [7:0] b);
    logic [CapW-1:0] limit;
    limit = (cur_capacity != '0) ? cur_capacity - 1'b1 : '0;
    if (overflowed) return;
    if (out_count >= limit) begin
      overflowed = 1'b1;
      return;
    end
    burst_q.push_back(b);
    out_count = out_count + 1'b1;
  endfunction

  // base64 alphabet value, -1 for anything else (padding included)
  function automatic int b64_sextet(logic [7:0] c);
    if (c >= "A" && c <= "Z") return c - "A";
    if (c >= "a" && c <= "z") return c - "a" + 26;
    if (c >= "0" && c <= "9") return c - "0" + 52;
    if (c == "+") return 62;
    if (c == "/") return 63;
    return -1;
  endfunction

  function automatic int hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  // quoted-printable byte with no escape open; an '=' on the last byte stays literal
  function automatic void qp_plain(logic [7:0] c, logic last);
    if (c == CharEq && !last) esc_state = EscEq;
    else put_decoded(c);
  endfunction

  // works out the results owed for one accepted request and queues them
  function automatic void decode_request(logic [7:0] c, logic last);
    int         v;
    int         hi;
    int         lo;
    int         n;
    logic [7:0] f;
    result_t    r;
    burst_q.delete();
    case (cur_mode)
      ModeB64: begin
        v = b64_sextet(c);
        if (v >= 0) begin
          b64_bits = {b64_bits[5:0], v[5:0]};
          b64_fill = b64_fill + 4'd6;
          if (b64_fill >= 4'd8) begin
            b64_fill = b64_fill - 4'd8;
            put_decoded(8'(b64_bits >> b64_fill));
          end
        end
      end
      ModeQp: begin
        if (esc_state == EscNone) begin
          qp_plain(c, last);
        end else if (esc_state == EscEq) begin
          if (last) begin
            put_decoded(CharEq);
            put_decoded(c);
            esc_state = EscNone;
          end else begin
            esc_held  = c;
            esc_state = EscFirst;
          end
        end else begin
          f         = esc_held;
          hi        = hex_nibble(f);
          lo        = hex_nibble(c);
          esc_state = EscNone;
          esc_held  = '0;
          // soft line break is dropped altogether
          if (!(f == CharCr && c == CharLf)) begin
            if (hi >= 0 && lo >= 0) begin
              put_decoded({hi[3:0], lo[3:0]});
            end else begin
              put_decoded(CharEq);
              // a second '=' reopens the escape with this byte as its first digit
              if (f == CharEq && !last) begin
                esc_state = EscFirst;
                esc_held  = c;
              end else begin
                put_decoded(f);
                qp_plain(c, last);
              end
            end
          end
        end
      end
      default: put_decoded(c);
    endcase
    n = (burst_q.size() > 0) ? burst_q.size() : 1;
    for (int k = 0; k < n; k++) begin
      r.data        = (burst_q.size() > 0) ? burst_q[k] : 8'h00;
      r.has_byte    = (burst_q.size() > 0);
      r.end_of_run  = (k == n - 1);
      r.stream_done = last;
      r.status      = overflowed;
      decoded_q.push_back(r);
    end
    if (last) clear_stream_state();
  endfunction

  // ---------------------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------------------

  // one request on the input stream; random idle cycles go in front of it
  task automatic send_item(logic [7:0] d, logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_request(d, last);
  endtask

  // sends everything in body_q in order, tlast on the final byte if close is set
  task automatic send_body(logic close);
    for (int i = 0; i < body_q.size(); i++) send_item(body_q[i], close && i == body_q.size() - 1);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    body_q.delete();
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
  endtask

  task automatic drain_results();
    while (decoded_q.size() != 0) @(posedge clk_i);
  endtask

  // register write, only once the block has handed out everything it owes
  task automatic write_reg(logic [1:0] idx, logic [CapW-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgIdxMode) cur_mode = value[1:0];
    else if (idx == CfgIdxCap) cur_capacity = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // output side back-pressure
  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  // ---------------------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------------------

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual data %h user %b last %b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        errors++;
      end else begin
        want = decoded_q.pop_front();
        check_field("out_byte", want.data, m_axis_tdata);
        check_field("has_byte", 8'(want.has_byte), 8'(m_axis_tuser[0]));
        check_field("stream_done", 8'(want.stream_done), 8'(m_axis_tuser[1]));
        check_field("status", 8'(want.status), 8'(m_axis_tuser[2]));
        check_field("end_of_run", 8'(want.end_of_run), 8'(m_axis_tlast));
      end
    end
  end

  // ends the run when no request moves on any channel for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles + 1 >= WatchdogLimit) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------------------

  // reset configuration: plain copy of the byte extremes
  task automatic test_pass_through();
    body_q.push_back(8'h00);
    body_q.push_back(8'hFF);
    send_body(1'b1);
  endtask

  // alphabet ends, and padding and a line feed that must be skipped
  task automatic test_base64();
    write_reg(CfgIdxMode, ModeB64);
    write_reg(CfgIdxCap, 17'd65536);
    add_text("TW+/=");
    body_q.push_back(CharLf);
    send_body(1'b1);
  endtask

  // hex escape, soft break, '=' '=' re-escape, bad escape (three results), '=' at the end
  task automatic test_quoted_printable();
    write_reg(CfgIdxMode, ModeQp);
    add_text("=4a=");
    body_q.push_back(CharCr);
    body_q.push_back(CharLf);
    add_text("==41=Gz=");
    send_body(1'b1);
    // escape opened with only one byte left
    add_text("=x");
    send_body(1'b1);
  endtask

  // smallest legal capacity, then capacities that leave no room at all
  task automatic test_capacity_limit();
    write_reg(CfgIdxMode, ModePass);
    write_reg(CfgIdxCap, 17'd2);
    add_text("abc");
    send_body(1'b1);
    write_reg(CfgIdxCap, 17'd1);
    add_text("ab");
    send_body(1'b1);
    write_reg(CfgIdxCap, 17'd0);
    add_text("a");
    send_body(1'b1);
  endtask

  task automatic test_reserved_mode();
    write_reg(CfgIdxMode, ModeReserved);
    write_reg(CfgIdxCap, 17'd4096);
    add_text("=Q");
    send_body(1'b1);
  endtask

  // mode flipped inside one stream: each decoder's state must survive the other's turn
  task automatic test_mode_switch();
    write_reg(CfgIdxMode, ModeQp);
    add_text("=");
    send_body(1'b0);
    write_reg(CfgIdxMode, ModeB64);
    add_text("TW");
    send_body(1'b0);
    write_reg(CfgIdxMode, ModeQp);
    add_text("41");
    send_body(1'b0);
    write_reg(CfgIdxMode, ModeB64);
    add_text("E");
    send_body(1'b1);
  endtask

  // mostly well-formed streams of the current mode with some noise, random configuration
  task automatic test_random_traffic(int idle_pct, int stall_pct, int budget);
    int sent;
    int len;
    int r;
    int idx;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < budget) begin
      if (sent == 0 || $urandom_range(2) == 0) begin
        write_reg(CfgIdxMode, 2'($urandom_range(3)));
        case ($urandom_range(3))
          0:       write_reg(CfgIdxCap, CapW'($urandom_range(12, 2)));
          1:       write_reg(CfgIdxCap, 17'd2);
          2:       write_reg(CfgIdxCap, 17'd65536);
          default: write_reg(CfgIdxCap, CapW'($urandom_range(400, 13)));
        endcase
      end
      len = $urandom_range(20, 1);
      while (body_q.size() < len) begin
        case (cur_mode)
          ModeB64: begin
            r = $urandom_range(99);
            if (r < 85) begin
              idx = $urandom_range(63);
              body_q.push_back(8'(idx < 26 ? "A" + idx : idx < 52 ? "a" + idx - 26 :
                                  idx < 62 ? "0" + idx - 52 : idx == 62 ? "+" : "/"));
            end else if (r < 92) begin
              case ($urandom_range(2))
                0:       body_q.push_back(CharEq);
                1:       body_q.push_back(CharCr);
                default: body_q.push_back(CharLf);
              endcase
            end else begin
              body_q.push_back(8'($urandom_range(255)));
            end
          end
          ModeQp: begin
            case ($urandom_range(9))
              0, 1, 2, 3, 4: body_q.push_back(8'($urandom_range(126, 32)));
              5, 6: begin
                body_q.push_back(CharEq);
                body_q.push_back(hex_digits[$urandom_range(21)]);
                body_q.push_back(hex_digits[$urandom_range(21)]);
              end
              7: begin
                body_q.push_back(CharEq);
                body_q.push_back(CharCr);
                body_q.push_back(CharLf);
              end
              default: body_q.push_back(8'($urandom_range(255)));
            endcase
          end
          default: body_q.push_back(8'($urandom_range(255)));
        endcase
      end
      sent = sent + body_q.size();
      send_body(1'b1);
      // after the first stream, hold the sender back until the block has caught up completely
      if (sent == len) drain_results();
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------------------

  initial begin
    cur_mode     = ResetMode;
    cur_capacity = ResetLimit + 1'b1;
    clear_stream_state();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_pass_through();
    test_base64();
    test_quoted_printable();
    test_capacity_limit();
    test_reserved_mode();
    test_mode_switch();

    test_random_traffic(0, 0, 25);
    test_random_traffic(69, 0, 25);
    test_random_traffic(0, 69, 25);
    test_random_traffic(22, 22, 25);

    // everything owed must arrive, and nothing after it
    drain_results();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
